>>> hw/rtl/gcr_pkg.sv
// Shared types, constants and helper functions of the glyph column rasterizer.
// No dependencies; imported by gcr_store, the top level, the checker and the testbench.
package gcr_pkg;

  localparam int unsigned GLYPH_COUNT = 96;
  localparam int unsigned MAX_COLUMNS = 8;
  localparam int unsigned MAX_ROWS    = 8;
  localparam int unsigned MAX_SCALE   = 8;
  localparam int unsigned STORE_DEPTH = GLYPH_COUNT * MAX_COLUMNS;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

  localparam logic [6:0] CODE_MASK   = 7'h7F;
  localparam logic [6:0] SPACE_CODE  = 7'd32;
  localparam logic [3:0] EMPTY_WIDTH = 4'd3;

  // Request codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_DRAW = 1'b1;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_GLYPH_COLUMNS = 2'd0;
  localparam logic [1:0] REG_GLYPH_ROWS    = 2'd1;
  localparam logic [1:0] REG_SCALE         = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIRST,
    ST_EMIT
  } gcr_state_e;

  // Port request into the glyph store
  typedef struct packed {
    logic                wr_en;
    logic                rd_en;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          wdata;
  } gcr_mem_req_t;

  // Saturate a register value into 1..hi.
  function automatic logic [3:0] clamp_cfg(logic [3:0] v, logic [3:0] hi);
    logic [3:0] r;
    r = v;
    if (v == 4'd0) r = 4'd1;
    else if (v > hi) r = hi;
    return r;
  endfunction

  // Stretch each set row bit into a run of sc mask bits.
  function automatic logic [63:0] expand_mask(logic [7:0] b, logic [3:0] sc);
    logic [63:0] run;
    logic [63:0] m;
    logic [5:0]  off;
    run = (64'd1 << sc) - 64'd1;
    m   = 64'd0;
    for (int i = 0; i < 8; i++) begin
      off = 6'(i) * {2'b00, sc};
      if (b[i]) m = m | (run << off);
    end
    return m;
  endfunction

endpackage

>>> hw/rtl/gcr_store.sv
// Glyph store: single-port synchronous RAM of column bytes, registered read.
// Depends on gcr_pkg for depth, address width and the request struct.
module gcr_store import gcr_pkg::*; (
  input  logic         clk_i,
  input  gcr_mem_req_t req_i,
  output logic [7:0]   rdata_o
);

  logic [7:0] mem_q [STORE_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/glyph_column_rasterizer_top.sv
// Glyph column rasterizer: top level with sequencer, config registers and output register.
// Depends on gcr_pkg and gcr_store.
//
// A load request writes one byte of the 768-byte glyph store (addresses 768 and
// up are dropped). A draw request scans the glyph and counts its nonzero columns
// through the single store port, then produces width*scale column results at one
// per cycle while the consumer keeps out_ready_i high. The store port is the
// limit: the scan reads one column a cycle, and the next source column is fetched
// while the last copy of the current one is handed out. Requests are taken one at
// a time; in_ready_o is high whenever no draw is in progress, even while the final
// result still waits in the output register. The store has no reset: draw only
// glyphs whose columns were loaded. Program glyph_columns, glyph_rows and scale
// only while idle; values of 0 act as 1 and values above 8 act as 8.
module glyph_column_rasterizer_top import gcr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [9:0]  store_addr_i,
  input  logic [7:0]  store_data_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  pos_x_i,
  input  logic [7:0]  pos_y_i,
  input  logic [15:0] colour_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [8:0]  col_x_o,
  output logic [7:0]  col_y_o,
  output logic [63:0] row_mask_o,
  output logic [15:0] pixel_colour_o,
  output logic [6:0]  advance_o,
  output logic        last_col_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers (raw 4-bit values; saturate where they are used)
  // ---------------------------------------------------------------------------
  logic [3:0] cfg_cols_q, cfg_rows_q, cfg_scale_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cols_q  <= 4'd6;
      cfg_rows_q  <= 4'd8;
      cfg_scale_q <= 4'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_GLYPH_COLUMNS: cfg_cols_q  <= pwdata[3:0];
        REG_GLYPH_ROWS:    cfg_rows_q  <= pwdata[3:0];
        REG_SCALE:         cfg_scale_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_GLYPH_COLUMNS: prdata = {28'd0, cfg_cols_q};
      REG_GLYPH_ROWS:    prdata = {28'd0, cfg_rows_q};
      REG_SCALE:         prdata = {28'd0, cfg_scale_q};
      default:           prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Glyph store
  // ---------------------------------------------------------------------------
  gcr_mem_req_t mem_req;
  logic [7:0]   mem_rdata;

  gcr_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and datapath registers
  // ---------------------------------------------------------------------------
  gcr_state_e state_q, state_d;

  logic [2:0]  scan_idx_q, scan_idx_d;
  logic [2:0]  col_idx_q, col_idx_d;
  logic [2:0]  sub_q, sub_d;
  logic [5:0]  j_q, j_d;
  logic [3:0]  count_q, count_d;
  logic        chk_q, chk_d;
  logic [9:0]  base_q, base_d;
  logic [3:0]  cols_q, cols_d, rows_q, rows_d, sc_q, sc_d;
  logic [7:0]  pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [15:0] colour_q, colour_d;

  logic        out_valid_q, out_valid_d;
  logic [8:0]  col_x_q, col_x_d;
  logic [7:0]  col_y_q, col_y_d;
  logic [63:0] mask_q, mask_d;
  logic [15:0] pcol_q, pcol_d;
  logic [6:0]  adv_q, adv_d;
  logic        last_q, last_d;

  logic        in_fire, draw_fire, emit_fire;
  logic        scan_last, sub_last, is_last, next_in_range, cur_in_range;
  logic [3:0]  width, col_next;
  logic [6:0]  glyph_num;
  logic [6:0]  code7;
  logic [3:0]  cols_eff;
  logic [7:0]  row_keep;
  logic [7:0]  adv_full;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign draw_fire  = in_fire && (func_i == FUNC_DRAW);
  assign emit_fire  = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  // Glyph index: control codes draw a space, the rest step down by 32.
  assign code7     = char_code_i[6:0] & CODE_MASK;
  assign glyph_num = (code7 < SPACE_CODE) ? 7'd0 : code7 - SPACE_CODE;
  assign cols_eff  = clamp_cfg(cfg_cols_q, 4'(MAX_COLUMNS));

  // Proportional width; an empty glyph still counts as three columns wide.
  assign width         = (count_q == 4'd0) ? EMPTY_WIDTH : count_q;
  assign scan_last     = ({1'b0, scan_idx_q} == cols_q - 4'd1);
  assign sub_last      = ({1'b0, sub_q} == sc_q - 4'd1);
  assign is_last       = ({1'b0, col_idx_q} == width - 4'd1) && sub_last;
  assign col_next      = {1'b0, col_idx_q} + 4'd1;
  assign next_in_range = (col_next < cols_q);
  assign cur_in_range  = ({1'b0, col_idx_q} < cols_q);
  assign row_keep      = 8'hFF >> (4'd8 - rows_q);
  assign adv_full      = ({4'd0, width + 4'd1}) * {4'd0, sc_q};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (draw_fire) state_d = ST_SCAN;
      ST_SCAN:  if (scan_last) state_d = ST_FIRST;
      ST_FIRST: state_d = ST_EMIT;
      ST_EMIT:  if (emit_fire && is_last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Store port: write on loads, read during the scan and ahead of each column.
  always_comb begin
    mem_req       = '0;
    mem_req.wdata = store_data_i;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && (func_i == FUNC_LOAD) && (store_addr_i < 10'(STORE_DEPTH))) begin
          mem_req.wr_en = 1'b1;
          mem_req.addr  = store_addr_i[STORE_AW-1:0];
        end
      end
      ST_SCAN: begin
        mem_req.rd_en = 1'b1;
        mem_req.addr  = STORE_AW'(base_q + {7'd0, scan_idx_q});
      end
      ST_FIRST: begin
        mem_req.rd_en = 1'b1;
        mem_req.addr  = STORE_AW'(base_q);
      end
      ST_EMIT: begin
        // prefetch the next source column with the last copy of this one
        if (emit_fire && sub_last && !is_last && next_in_range) begin
          mem_req.rd_en = 1'b1;
          mem_req.addr  = STORE_AW'(base_q + {6'd0, col_next});
        end
      end
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    scan_idx_d  = scan_idx_q;
    col_idx_d   = col_idx_q;
    sub_d       = sub_q;
    j_d         = j_q;
    count_d     = count_q;
    chk_d       = (state_q == ST_SCAN);
    base_d      = base_q;
    cols_d      = cols_q;
    rows_d      = rows_q;
    sc_d        = sc_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    colour_d    = colour_q;
    out_valid_d = out_valid_q && !out_ready_i;
    col_x_d     = col_x_q;
    col_y_d     = col_y_q;
    mask_d      = mask_q;
    pcol_d      = pcol_q;
    adv_d       = adv_q;
    last_d      = last_q;

    // count nonzero columns as the scan reads return
    if (chk_q && (mem_rdata != 8'd0)) count_d = count_q + 4'd1;

    case (state_q)
      ST_IDLE: begin
        if (draw_fire) begin
          cols_d     = cols_eff;
          rows_d     = clamp_cfg(cfg_rows_q, 4'(MAX_ROWS));
          sc_d       = clamp_cfg(cfg_scale_q, 4'(MAX_SCALE));
          base_d     = 10'({4'd0, glyph_num} * {7'd0, cols_eff});
          pos_x_d    = pos_x_i;
          pos_y_d    = pos_y_i;
          colour_d   = colour_i;
          scan_idx_d = 3'd0;
          count_d    = 4'd0;
        end
      end
      ST_SCAN: scan_idx_d = scan_idx_q + 3'd1;
      ST_FIRST: begin
        col_idx_d = 3'd0;
        sub_d     = 3'd0;
        j_d       = 6'd0;
      end
      ST_EMIT: begin
        if (emit_fire) begin
          out_valid_d = 1'b1;
          col_x_d     = {1'b0, pos_x_q} + {3'd0, j_q};
          col_y_d     = pos_y_q;
          mask_d      = cur_in_range ? expand_mask(mem_rdata & row_keep, sc_q) : 64'd0;
          pcol_d      = colour_q;
          adv_d       = is_last ? adv_full[6:0] : 7'd0;
          last_d      = is_last;
          j_d         = j_q + 6'd1;
          if (sub_last) begin
            sub_d     = 3'd0;
            col_idx_d = col_idx_q + 3'd1;
          end else begin
            sub_d = sub_q + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      scan_idx_q  <= 3'd0;
      col_idx_q   <= 3'd0;
      sub_q       <= 3'd0;
      j_q         <= 6'd0;
      count_q     <= 4'd0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_idx_q  <= scan_idx_d;
      col_idx_q   <= col_idx_d;
      sub_q       <= sub_d;
      j_q         <= j_d;
      count_q     <= count_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    cols_q   <= cols_d;
    rows_q   <= rows_d;
    sc_q     <= sc_d;
    pos_x_q  <= pos_x_d;
    pos_y_q  <= pos_y_d;
    colour_q <= colour_d;
    col_x_q  <= col_x_d;
    col_y_q  <= col_y_d;
    mask_q   <= mask_d;
    pcol_q   <= pcol_d;
    adv_q    <= adv_d;
    last_q   <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign col_x_o        = col_x_q;
  assign col_y_o        = col_y_q;
  assign row_mask_o     = mask_q;
  assign pixel_colour_o = pcol_q;
  assign advance_o      = adv_q;
  assign last_col_o     = last_q;

endmodule

>>> hw/rtl/gcr_checker.sv
// Port-level checks for the glyph column rasterizer, bound to the top level.
// Depends on gcr_pkg for request codes.
module gcr_checker import gcr_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       func_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [6:0] advance_o,
  input logic       last_col_o
);

  // hold a result until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped before it was taken");

  // advance appears on the final column only
  a_adv_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((advance_o != 7'd0) == last_col_o))
    else $error("advance does not match last column flag");

  // a draw request blocks further requests while it is in progress
  a_draw_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (func_i == FUNC_DRAW)) |=> !in_ready_o)
    else $error("request taken during a draw");

  // a load request produces no result
  a_load_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (func_i == FUNC_LOAD) && !out_valid_o) |=> !out_valid_o)
    else $error("load produced a result");

endmodule

bind glyph_column_rasterizer_top gcr_checker u_gcr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .func_i      (func_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .advance_o   (advance_o),
  .last_col_o  (last_col_o)
);

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for glyph_column_rasterizer_top: loads glyph columns, draws
// characters under several register settings and checks every column result.
// Depends on gcr_pkg and the rasterizer RTL; reads no files.
module tb_top;
  import gcr_pkg::*;

  // Allowed run of cycles without any request or result moving. The longest honest
  // stretch is the deliberate receiver hold plus a scan, far below this.
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned LONG_HOLD     = 300;
  // A load has no result, so let the block finish it before the registers change.
  localparam int unsigned SETTLE_CYCLES = 10;
  // Tail after the last result: longer than one full draw.
  localparam int unsigned DRAIN_CYCLES  = 100;
  // Register index past the end of the map; writes to it must be dropped.
  localparam logic [1:0]  REG_UNUSED    = 2'd3;

  typedef struct packed {
    logic        func;
    logic [9:0]  addr;
    logic [7:0]  data;
    logic [7:0]  code;
    logic [7:0]  px;
    logic [7:0]  py;
    logic [15:0] colour;
  } glyph_req_t;

  typedef struct packed {
    logic [8:0]  x;
    logic [7:0]  y;
    logic [63:0] mask;
    logic [15:0] colour;
    logic [6:0]  advance;
    logic        last_col;
  } column_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = FUNC_LOAD;
  logic [9:0]  store_addr = '0;
  logic [7:0]  store_data = '0;
  logic [7:0]  char_code = '0;
  logic [7:0]  pos_x = '0;
  logic [7:0]  pos_y = '0;
  logic [15:0] colour = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [8:0]  col_x;
  logic [7:0]  col_y;
  logic [63:0] row_mask;
  logic [15:0] pixel_colour;
  logic [6:0]  advance;
  logic        last_col;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  glyph_column_rasterizer_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .func_i         (func),
    .store_addr_i   (store_addr),
    .store_data_i   (store_data),
    .char_code_i    (char_code),
    .pos_x_i        (pos_x),
    .pos_y_i        (pos_y),
    .colour_i       (colour),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .col_x_o        (col_x),
    .col_y_o        (col_y),
    .row_mask_o     (row_mask),
    .pixel_colour_o (pixel_colour),
    .advance_o      (advance),
    .last_col_o     (last_col),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: private copy of the glyph store and the raw register values
  // ---------------------------------------------------------------------------
  logic [7:0]  glyph_mem [STORE_DEPTH];
  logic [3:0]  cfg_cols  = 4'd6;
  logic [3:0]  cfg_rows  = 4'd8;
  logic [3:0]  cfg_scale = 4'd1;
  column_t     pending_columns [$];
  int unsigned errors = 0;

  // Stimulus state: requests waiting for the driver, and which store bytes the
  // requests queued so far have written (never draw a glyph with holes in it).
  glyph_req_t  pending_reqs [$];
  bit          written_map [STORE_DEPTH];
  int unsigned queued = 0;

  // Handshake bookkeeping shared between the clocked processes.
  logic        req_taken = 1'b0;
  logic        calm = 1'b0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned long_hold = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned idle_cycles = 0;

  // Saturate a register value: 0 behaves as 1, anything above hi as hi.
  function automatic int unsigned sat_field(input logic [3:0] v, input int unsigned hi);
    if (v == 4'd0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic int unsigned glyph_cols();
    return sat_field(cfg_cols, MAX_COLUMNS);
  endfunction

  // Work out the column results of one accepted request; a load only updates the
  // store copy (addresses past the store are dropped).
  task automatic rasterize_request(input glyph_req_t r);
    int unsigned cols, rows, sc, glyph, base, width, total, src, j, k;
    logic [6:0]  code7;
    logic [7:0]  cbyte;
    column_t     c;
    if (r.func == FUNC_LOAD) begin
      if (r.addr < STORE_DEPTH) glyph_mem[r.addr] = r.data;
    end else begin
      cols  = glyph_cols();
      rows  = sat_field(cfg_rows, MAX_ROWS);
      sc    = sat_field(cfg_scale, MAX_SCALE);
      code7 = r.code[6:0];
      glyph = (code7 < SPACE_CODE) ? 0 : code7 - SPACE_CODE;
      base  = glyph * cols;
      width = 0;
      for (j = 0; j < cols; j++)
        if (glyph_mem[base + j] != 8'h00) width++;
      if (width == 0) width = EMPTY_WIDTH;
      total = width * sc;
      for (j = 0; j < total; j++) begin
        src = j / sc;
        // Columns past the stored ones read as empty.
        cbyte  = (src < cols) ? glyph_mem[base + src] : 8'h00;
        c.mask = '0;
        for (k = 0; k < rows * sc; k++) c.mask[k] = cbyte[k / sc];
        c.x        = 9'(r.px + j);
        c.y        = r.py;
        c.colour   = r.colour;
        c.last_col = (j == total - 1);
        c.advance  = c.last_col ? 7'((width + 1) * sc) : 7'd0;
        pending_columns.push_back(c);
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_column();
    column_t e;
    if (pending_columns.size() == 0) begin
      $display("%0t: column result at x %0h with no draw pending", $time, col_x);
      errors++;
    end else begin
      e = pending_columns.pop_front();
      compare_field("col_x", e.x, col_x);
      compare_field("col_y", e.y, col_y);
      compare_field("row_mask", e.mask, row_mask);
      compare_field("pixel_colour", e.colour, pixel_colour);
      compare_field("advance", e.advance, advance);
      compare_field("last_col", e.last_col, last_col);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sampling at the rising edge: predict on each accepted request, check each
  // accepted result, and run the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      req_taken <= in_valid && in_ready;
      if (in_valid && in_ready)
        rasterize_request('{func, store_addr, store_data, char_code, pos_x, pos_y, colour});
      if (out_valid && out_ready) check_column();
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles", $time, IDLE_LIMIT);
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driver: change inputs on the falling edge. Hold valid and payload until
  // the request is taken, then either present the next one or drop valid for a gap.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_requests
    glyph_req_t r;
    if (rst_n && (!in_valid || req_taken)) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        // Random gap: drop valid now, then count down send_gap.
        send_gap <= $urandom_range(0, 18);
        in_valid <= 1'b0;
      end else begin
        r = pending_reqs.pop_front();
        in_valid   <= 1'b1;
        func       <= r.func;
        store_addr <= r.addr;
        store_data <= r.data;
        char_code  <= r.code;
        pos_x      <= r.px;
        pos_y      <= r.py;
        colour     <= r.colour;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stall bursts, plus one long hold on request from the
  // sequence so the block fills up and backs up its request channel.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      long_hold <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (long_hold != 0) begin
      long_hold <= long_hold - 1;
      out_ready <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap  <= recv_gap - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      recv_gap  <= $urandom_range(0, 18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_req(input logic fn, input logic [9:0] addr, input logic [7:0] data,
                          input logic [7:0] code, input logic [7:0] px,
                          input logic [7:0] py, input logic [15:0] col);
    if (fn == FUNC_LOAD && addr < STORE_DEPTH) written_map[addr] = 1'b1;
    pending_reqs.push_back('{fn, addr, data, code, px, py, col});
    queued++;
  endtask

  // Fill the unused fields with noise so every payload bit toggles.
  task automatic load_byte(input logic [9:0] addr, input logic [7:0] data);
    push_req(FUNC_LOAD, addr, data, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
  endtask

  task automatic draw_char(input logic [7:0] code);
    push_req(FUNC_DRAW, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)), code,
             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
             16'($urandom_range(0, 65535)));
  endtask

  // Pick a code that selects glyph g; bit 7 is don't-care and glyph 0 is also
  // reached through the control codes.
  function automatic logic [7:0] code_for(input int unsigned g);
    logic [7:0] c;
    if (g == 0 && $urandom_range(0, 1) != 0) c = 8'($urandom_range(0, SPACE_CODE - 1));
    else c = 8'(g + SPACE_CODE);
    c[7] = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic bit glyph_ready(input int unsigned g);
    int unsigned j;
    for (j = 0; j < glyph_cols(); j++)
      if (!written_map[g * glyph_cols() + j]) return 1'b0;
    return 1'b1;
  endfunction

  // Load every stored column of glyph g under the current layout.
  task automatic define_glyph(input int unsigned g);
    int unsigned kind, j;
    logic [7:0]  b;
    kind = $urandom_range(0, 5);
    for (j = 0; j < glyph_cols(); j++) begin
      case (kind)
        0:       b = 8'h00;   // empty glyph, falls back to the default width
        1:       b = 8'hFF;
        2:       b = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        default: b = 8'($urandom_range(0, 255));
      endcase
      load_byte(10'(g * glyph_cols() + j), b);
    end
  endtask

  // Mostly define-then-draw sequences; some redraws of loaded glyphs and some
  // stray loads, a quarter of them past the end of the store.
  task automatic random_items(input int unsigned n);
    int unsigned target, pick, g, tries;
    target = queued + n;
    while (queued < target) begin
      pick = $urandom_range(0, 9);
      g    = $urandom_range(0, GLYPH_COUNT - 1);
      tries = 0;
      while (pick >= 8 && tries < 8 && !glyph_ready(g)) begin
        g = $urandom_range(0, GLYPH_COUNT - 1);
        tries++;
      end
      if (pick == 6 || pick == 7) begin
        load_byte(10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
      end else begin
        if (pick < 6 || !glyph_ready(g)) define_glyph(g);
        draw_char(code_for(g));
        if ($urandom_range(0, 2) == 0) draw_char(code_for(g));
      end
    end
  endtask

  // Wait until every queued request went in and every predicted column came out.
  // Poll at the rising edge, where the driver's falling-edge updates have settled.
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_valid || pending_columns.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write: setup, then access with penable.
  task automatic cfg_write(input logic [1:0] idx, input logic [3:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {28'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GLYPH_COLUMNS: cfg_cols  = value;
      REG_GLYPH_ROWS:    cfg_rows  = value;
      REG_SCALE:         cfg_scale = value;
      default:           ;
    endcase
  endtask

  // Drain, reprogram all registers (plus a dropped write), queue at least n random requests.
  task automatic run_phase(input logic [3:0] cols, input logic [3:0] rows,
                           input logic [3:0] sc, input int unsigned n);
    wait_idle();
    cfg_write(REG_GLYPH_COLUMNS, cols);
    cfg_write(REG_GLYPH_ROWS, rows);
    cfg_write(REG_SCALE, sc);
    cfg_write(REG_UNUSED, 4'($urandom_range(0, 15)));
    random_items(n);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset layout (6 columns, 8 rows, scale 1).
    // Empty space glyph: drawn three columns wide with blank masks.
    for (int j = 0; j < 6; j++) load_byte(10'(j), 8'h00);
    push_req(FUNC_DRAW, 10'h3FF, 8'hFF, 8'h00, 8'h00, 8'h00, 16'h0000);
    push_req(FUNC_DRAW, 10'h000, 8'h00, 8'h9F, 8'hFF, 8'hFF, 16'hFFFF);
    push_req(FUNC_DRAW, 10'h155, 8'hAA, 8'd32, 8'h80, 8'h01, 16'h5A5A);
    // Last glyph with holes: three nonzero columns, but the first three stored
    // columns (two of them blank) are the ones drawn.
    load_byte(10'd570, 8'h00);
    load_byte(10'd571, 8'h81);
    load_byte(10'd572, 8'h00);
    load_byte(10'd573, 8'hFF);
    load_byte(10'd574, 8'h00);
    load_byte(10'd575, 8'h01);
    push_req(FUNC_DRAW, 10'h2AA, 8'h55, 8'h7F, 8'hFA, 8'h00, 16'h0001);
    push_req(FUNC_DRAW, 10'h0F0, 8'h0F, 8'hFF, 8'h00, 8'hFF, 16'h8000);
    // Loads past the end of the store are dropped.
    push_req(FUNC_LOAD, 10'd768, 8'hFF, 8'h00, 8'h00, 8'h00, 16'h0000);
    push_req(FUNC_LOAD, 10'h3FF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);

    // Largest layout: up to 64 columns of 64-bit masks. Hold the result side off
    // for a long stretch so the request channel backs up behind a stalled draw.
    run_phase(4'd8, 4'd8, 4'd8, 8);
    hold_reqs++;
    // Smallest layout, so empty glyphs run past the stored column.
    run_phase(4'd1, 4'd1, 4'd1, 10);
    // Zero and oversize values saturate.
    run_phase(4'd0, 4'd0, 4'd0, 6);
    run_phase(4'd15, 4'd15, 4'd15, 6);

    // Random layouts, mostly with small scale to keep draws short. Pause the
    // request side midway until every result is back.
    repeat (3) begin
      run_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 3)), 6);
      wait_idle();
      random_items(6);
    end

    // Final stretch at full rate on both sides.
    wait_idle();
    calm = 1'b1;
    run_phase(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
              4'($urandom_range(1, 3)), 12);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
